// ===== rtl/core/swmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter: shared package
// Default sizes, the window size register format and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package swmf_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window size register
    localparam int              CFG_BITS  = 5;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic shift;    // take the new sample into the window
        logic start;    // begin the rank scan at the newest sample
        logic advance;  // move to the next candidate
        logic load;     // capture the current candidate as the median
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic will_emit; // window full once the offered sample is taken
        logic hit;       // current candidate sits at the median position
    } t_sts;

endpackage

// ===== rtl/core/swmf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter: datapath
// Sample shift line, fill count, window size register, and a rank unit that
// checks one candidate per cycle against every sample in the window.
// ----------------------------------------------------------------------------
module swmf_datapath #(
    parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swmf_pkg::t_cmd                i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_we,
    input  logic [swmf_pkg::CFG_BITS-1:0] i_cfg_data,
    output swmf_pkg::t_sts                o_sts,
    output logic signed [SAMPLE_BITS-1:0] o_median
);
    import swmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic signed [SAMPLE_BITS-1:0] r_taps [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_median;
    logic [CNT_W-1:0]              r_fill;
    logic [CNT_W-1:0]              n_fill;
    logic [CFG_BITS-1:0]           r_win_size;
    logic [IDX_W-1:0]              r_k;
    logic [31:0]                   cfg_ext;
    logic [CNT_W-1:0]              w_eff;
    logic [CNT_W-1:0]              rank;
    logic [MAX_WINDOW-1:0]         below;
    logic signed [SAMPLE_BITS-1:0] cand;

    // Window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_win_size <= i_cfg_data;
        end
    end

    // Clamp the window size to 1 .. MAX_WINDOW
    always_comb begin
        cfg_ext = 32'(r_win_size);
        if (cfg_ext == 32'd0) begin
            w_eff = CNT_W'(1);
        end else if (cfg_ext > 32'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(cfg_ext);
        end
    end

    // Saturating count of samples since reset
    assign n_fill = (r_fill == CNT_W'(MAX_WINDOW)) ? r_fill : r_fill + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.shift) begin
            r_fill <= n_fill;
        end
    end

    // Shift line, newest sample at tap zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_taps[0] <= i_sample;
            for (int j = 1; j < MAX_WINDOW; j++) begin
                r_taps[j] <= r_taps[j-1];
            end
        end
    end

    // Candidate index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.start) begin
            r_k <= '0;
        end else if (i_cmd.advance) begin
            r_k <= r_k + IDX_W'(1);
        end
    end

    // Rank of the candidate: smaller samples, plus equal ones at newer taps
    assign cand = r_taps[r_k];

    always_comb begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            below[j] = (CNT_W'(j) < w_eff) &&
                       ((r_taps[j] < cand) ||
                        ((r_taps[j] == cand) && (IDX_W'(j) < r_k)));
        end
    end

    assign rank = CNT_W'($countones(below));

    assign o_sts.will_emit = (n_fill >= w_eff);
    assign o_sts.hit       = (rank == (w_eff >> 1));

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_median <= cand;
        end
    end

    assign o_median = r_median;

endmodule

// ===== rtl/core/swmf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter: controller
// Sequences sample intake and the rank scan, and owns the result valid flag.
// ----------------------------------------------------------------------------
module swmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  swmf_pkg::t_sts i_sts,
    output swmf_pkg::t_cmd o_cmd
);
    import swmf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Commands to the datapath
    always_comb begin
        o_cmd.shift   = in_xfer;
        o_cmd.start   = in_xfer && i_sts.will_emit;
        o_cmd.advance = (r_state == S_SCAN) && !i_sts.hit;
        o_cmd.load    = (r_state == S_SCAN) && i_sts.hit && out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_sts.will_emit) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (o_cmd.load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    assign n_out_valid = o_cmd.load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A capture only happens on a rank match
    a_load_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.hit)
        else $error("median captured without rank match");

    // A capture always presents a result next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("captured median not presented");

    // A sample that fills the window starts a scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_sts.will_emit) |=> (r_state == S_SCAN) && o_in_stall)
        else $error("full window did not start a scan");

endmodule

// ===== rtl/core/sliding_window_median_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter: top level
// Median of the most recent window_size signed samples.
// ----------------------------------------------------------------------------
// One sample per input transfer. No result appears until window_size samples
// have arrived since reset; after that each sample yields the element at
// sorted position window_size/2 of the newest window_size samples (upper
// middle for an even window). A window size of zero acts as one, and sizes
// above MAX_WINDOW act as MAX_WINDOW. A sample that yields a result is taken
// in, then a rank scan tests one candidate per cycle against the whole
// window and stops at the median, waiting there while an earlier result is
// still stalled in the output register. Input is stalled during the scan; the
// result sits in an output register, so the next sample is taken while it
// waits. Write window_size only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
    parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmf_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_median
);
    import swmf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    swmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Window storage and rank unit
    swmf_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_sample  (i_sample),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_sts     (sts),
        .o_median  (o_median)
    );

endmodule
